FILE: rtl/u8d_pkg.sv
// Package for the UTF-8 stream decoder: result status codes, the result
// beat struct and queue sizing constants. No dependencies.
package u8d_pkg;

  // Width of a decoded code point
  localparam int unsigned CP_W = 21;

  // Result queue: four entries, one decode step pushes at most two
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Result status codes
  typedef enum logic [1:0] {
    ST_CODE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_END     = 2'd2
  } status_t;

  // One result beat
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    status_t         status;
    logic            last;
  } result_t;

endpackage

FILE: rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: byte input channel, result channel.
// Depends on u8d_pkg, u8d_decode and u8d_queue.
//
// Usage:
//   Input channel: one raw UTF-8 byte per beat on in_byte_in, taken when
//   in_valid is high and in_stall is low.
//   Result channel: one result per beat (out_code_point, out_status,
//   out_last), taken when out_valid is high and out_stall is low. A byte
//   gives zero results (lead byte or inner continuation), one, or two (a
//   bad continuation followed by a retried lead); out_last marks the
//   final result of its byte.
//   A result is written into the result queue when its byte is taken and
//   reaches the output once the results ahead of it have left. Throughput:
//   one byte per cycle while the receiver keeps up; the queue delivers one
//   beat per cycle while out_stall is low, so two results take two beats.
//   Stall: the decoder decodes as it takes; results wait in a four-entry
//   queue, and in_stall rises when fewer than two entries are free.
//   Reset (rst_n low, synchronous): the open sequence is dropped and the
//   queue emptied; the block takes bytes in the next cycle.
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CP_W-1:0]   out_code_point,
  output logic [1:0]        out_status,
  output logic              out_last
);

  logic       take;
  logic       room2;
  logic       not_empty;
  logic [1:0] res_cnt;
  result_t    res0, res1, head;

  // Handshake
  assign in_stall  = !room2;
  assign take      = in_valid && room2;
  assign out_valid = not_empty;

  u8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (in_byte_in),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .pop       (not_empty && !out_stall),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  // Result beat fields
  assign out_code_point = head.code_point;
  assign out_status     = head.status;
  assign out_last       = head.last;

endmodule

FILE: rtl/u8d_decode.sv
// Byte decoder: holds the open-sequence state and turns one input byte
// into zero, one or two result beats. Depends on u8d_pkg.
module u8d_decode
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      byte_in,
  output result_t         res0,
  output result_t         res1,
  output logic [1:0]      res_cnt
);

  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [1:0]      remain_r, remain_nxt;

  logic            lead_ascii;
  logic            lead_open;
  logic [1:0]      lead_rem;
  logic [CP_W-1:0] lead_pay;
  logic [CP_W-1:0] shifted;

  // Classify the byte as a lead byte
  always_comb begin
    lead_ascii = 1'b0;
    lead_open  = 1'b0;
    lead_rem   = 2'd0;
    lead_pay   = '0;
    priority if (byte_in[7] == 1'b0) begin
      lead_ascii = 1'b1;
    end else if (byte_in[7:5] == 3'b110) begin
      lead_open = 1'b1;
      lead_rem  = 2'd1;
      lead_pay  = {16'd0, byte_in[4:0]};
    end else if (byte_in[7:4] == 4'b1110) begin
      lead_open = 1'b1;
      lead_rem  = 2'd2;
      lead_pay  = {17'd0, byte_in[3:0]};
    end else if (byte_in[7:3] == 5'b11110) begin
      lead_open = 1'b1;
      lead_rem  = 2'd3;
      lead_pay  = {18'd0, byte_in[2:0]};
    end else begin
      // one leading one, or five and more: bad lead
    end
  end

  assign shifted = {partial_r[CP_W-7:0], byte_in[5:0]};

  // Step decode: results and next sequence state
  always_comb begin
    res0        = '0;
    res1        = '0;
    res_cnt     = 2'd0;
    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    priority if (byte_in == 8'd0) begin
      // end of text drops any open sequence
      partial_nxt     = '0;
      remain_nxt      = 2'd0;
      res0.status     = ST_END;
      res0.last       = 1'b1;
      res_cnt         = 2'd1;
    end else if (remain_r != 2'd0) begin
      if (byte_in[7:6] == 2'b10) begin
        // continuation: shift in six payload bits
        remain_nxt  = remain_r - 2'd1;
        partial_nxt = shifted;
        if (remain_r == 2'd1) begin
          res0.code_point = shifted;
          res0.status     = ST_CODE;
          res0.last       = 1'b1;
          res_cnt         = 2'd1;
          partial_nxt     = '0;
        end
      end else begin
        // bad continuation: invalid, then retry the byte as a lead
        partial_nxt = '0;
        remain_nxt  = 2'd0;
        res0.status = ST_INVALID;
        if (lead_ascii) begin
          res1.code_point = {13'd0, byte_in};
          res1.status     = ST_CODE;
          res1.last       = 1'b1;
          res_cnt         = 2'd2;
        end else if (lead_open) begin
          partial_nxt = lead_pay;
          remain_nxt  = lead_rem;
          res0.last   = 1'b1;
          res_cnt     = 2'd1;
        end else begin
          res1.status = ST_INVALID;
          res1.last   = 1'b1;
          res_cnt     = 2'd2;
        end
      end
    end else begin
      // no sequence open
      if (lead_ascii) begin
        res0.code_point = {13'd0, byte_in};
        res0.status     = ST_CODE;
        res0.last       = 1'b1;
        res_cnt         = 2'd1;
      end else if (lead_open) begin
        partial_nxt = lead_pay;
        remain_nxt  = lead_rem;
      end else begin
        res0.status = ST_INVALID;
        res0.last   = 1'b1;
        res_cnt     = 2'd1;
      end
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      remain_r  <= 2'd0;
    end else if (take) begin
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
    end
  end

endmodule

FILE: rtl/u8d_queue.sv
// Result queue: four-entry register queue that takes up to two beats per
// cycle and hands out one. Depends on u8d_pkg.
module u8d_queue
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [1:0] push_cnt,
  input  result_t    push0,
  input  result_t    push1,
  input  logic       pop,
  output result_t    head,
  output logic       not_empty,
  output logic       room2
);

  result_t            mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, wr_nxt;
  logic [QPTR_W-1:0]  rd_r, rd_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [QCNT_W-1:0]  add;
  logic [QPTR_W-1:0]  wr_p1;

  assign add       = push ? {1'b0, push_cnt} : '0;
  assign wr_p1     = wr_r + 1'b1;
  assign wr_nxt    = wr_r + add[QPTR_W-1:0];
  assign rd_nxt    = pop ? rd_r + 1'b1 : rd_r;
  assign cnt_nxt   = cnt_r + add - {{(QCNT_W-1){1'b0}}, pop};

  assign head      = mem[rd_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= QCNT_W'(QDEPTH - 2));

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push && push_cnt != 2'd0) begin
      mem[wr_r] <= push0;
    end
    if (push && push_cnt == 2'd2) begin
      mem[wr_p1] <= push1;
    end
  end

endmodule
